// ===== rtl/pfgr_pkg.sv =====
// Package for the page framebuffer glyph renderer: panel geometry, request
// codes, controller/datapath interface structs and the 5x7 font table.
// No dependencies.
package pfgr_pkg;

  // Panel geometry
  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
  localparam int COL_W        = $clog2(PANEL_WIDTH);
  localparam int PG_W         = 3;
  localparam int ADDR_W       = PG_W + COL_W;
  localparam int MEM_DEPTH    = PAGE_COUNT * (2 ** COL_W);
  localparam int LAST_ROWS    = PANEL_HEIGHT - 8 * (PAGE_COUNT - 1);
  localparam logic [7:0] LAST_PAGE_MASK = 8'((16'd1 << LAST_ROWS) - 16'd1);
  localparam int GLYPH_COLS   = 5;

  // Request kinds
  localparam logic [1:0] REQ_GLYPH = 2'd0;
  localparam logic [1:0] REQ_PIXEL = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture request
    logic acc_rd;    // read byte of current pixel/glyph access
    logic acc_wr;    // write back modified byte
    logic acc_next;  // step to next glyph access
    logic clr_wr;    // write zero during page clear
    logic init_wr;   // write zero during power-on sweep
    logic byte_rd;   // read column byte
    logic out_load;  // load result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] in_type;
    logic       acc_valid;
    logic       acc_last;
    logic       page_ok;
    logic       sweep_last;
    logic       init_last;
    logic       rd_ok;
  } dp_stat_t;

  // One column of a glyph, bit 0 is the top row. Codes outside the font
  // fall back to the underscore glyph.
  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
    logic [39:0] g;
    logic [7:0]  c;
    case (code)
      8'h20: g = 40'h0000000000;  8'h21: g = 40'h00005F0000;  8'h22: g = 40'h0007000700;
      8'h23: g = 40'h147F147F14;  8'h24: g = 40'h242A7F2A12;  8'h25: g = 40'h2313086462;
      8'h26: g = 40'h3649552250;  8'h27: g = 40'h0005030000;  8'h28: g = 40'h001C224100;
      8'h29: g = 40'h0041221C00;  8'h2A: g = 40'h082A1C2A08;  8'h2B: g = 40'h08083E0808;
      8'h2C: g = 40'h0050300000;  8'h2D: g = 40'h0808080808;  8'h2E: g = 40'h0060600000;
      8'h2F: g = 40'h2010080402;  8'h30: g = 40'h3E5149453E;  8'h31: g = 40'h00427F4000;
      8'h32: g = 40'h4261514946;  8'h33: g = 40'h2141454B31;  8'h34: g = 40'h1814127F10;
      8'h35: g = 40'h2745454539;  8'h36: g = 40'h3C4A494930;  8'h37: g = 40'h0171090503;
      8'h38: g = 40'h3649494936;  8'h39: g = 40'h064949291E;  8'h3A: g = 40'h0036360000;
      8'h3B: g = 40'h0056360000;  8'h3C: g = 40'h0008142241;  8'h3D: g = 40'h1414141414;
      8'h3E: g = 40'h4122140800;  8'h3F: g = 40'h0201510906;  8'h40: g = 40'h324979413E;
      8'h41: g = 40'h7E1111117E;  8'h42: g = 40'h7F49494936;  8'h43: g = 40'h3E41414122;
      8'h44: g = 40'h7F4141221C;  8'h45: g = 40'h7F49494941;  8'h46: g = 40'h7F09090101;
      8'h47: g = 40'h3E41415132;  8'h48: g = 40'h7F0808087F;  8'h49: g = 40'h00417F4100;
      8'h4A: g = 40'h2040413F01;  8'h4B: g = 40'h7F08142241;  8'h4C: g = 40'h7F40404040;
      8'h4D: g = 40'h7F0204027F;  8'h4E: g = 40'h7F0408107F;  8'h4F: g = 40'h3E4141413E;
      8'h50: g = 40'h7F09090906;  8'h51: g = 40'h3E4151215E;  8'h52: g = 40'h7F09192946;
      8'h53: g = 40'h4649494931;  8'h54: g = 40'h01017F0101;  8'h55: g = 40'h3F4040403F;
      8'h56: g = 40'h1F2040201F;  8'h57: g = 40'h7F2018207F;  8'h58: g = 40'h6314081463;
      8'h59: g = 40'h0304780403;  8'h5A: g = 40'h6151494543;  8'h5B: g = 40'h00007F4141;
      8'h5C: g = 40'h0204081020;  8'h5D: g = 40'h41417F0000;  8'h5E: g = 40'h0402010204;
      8'h5F: g = 40'h4040404040;  8'h60: g = 40'h0001020400;  8'h61: g = 40'h2054545478;
      8'h62: g = 40'h7F48444438;  8'h63: g = 40'h3844444420;  8'h64: g = 40'h384444487F;
      8'h65: g = 40'h3854545418;  8'h66: g = 40'h087E090102;  8'h67: g = 40'h081454543C;
      8'h68: g = 40'h7F08040478;  8'h69: g = 40'h00447D4000;  8'h6A: g = 40'h2040443D00;
      8'h6B: g = 40'h007F102844;  8'h6C: g = 40'h00417F4000;  8'h6D: g = 40'h7C04180478;
      8'h6E: g = 40'h7C08040478;  8'h6F: g = 40'h3844444438;  8'h70: g = 40'h7C14141408;
      8'h71: g = 40'h081414187C;  8'h72: g = 40'h7C08040408;  8'h73: g = 40'h4854545420;
      8'h74: g = 40'h043F444020;  8'h75: g = 40'h3C4040207C;  8'h76: g = 40'h1C2040201C;
      8'h77: g = 40'h3C4030403C;  8'h78: g = 40'h4428102844;  8'h79: g = 40'h0C5050503C;
      8'h7A: g = 40'h4464544C44;
      default: g = 40'h4040404040;
    endcase
    // leftmost column sits in the top byte
    case (col)
      3'd0:    c = g[39:32];
      3'd1:    c = g[31:24];
      3'd2:    c = g[23:16];
      3'd3:    c = g[15:8];
      3'd4:    c = g[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/pfgr_datapath.sv =====
// Datapath of the glyph renderer: request registers, single-port page
// store, access address/mask generation, sweep counters, result register.
// Depends on pfgr_pkg.
module pfgr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         in_tdata,
  input  pfgr_pkg::dp_cmd_t   cmd,
  output pfgr_pkg::dp_stat_t  stat,
  output logic [7:0]          out_tdata
);

  // Request registers
  logic [1:0] req_type_r;
  logic [8:0] x_r;
  logic [8:0] y_r;
  logic [7:0] code_r;
  logic       on_r;
  logic [2:0] page_r;

  // Access counters
  logic [2:0]                    col_r, col_nxt;
  logic                          half_r, half_nxt;
  logic [pfgr_pkg::COL_W-1:0]    sweep_r;
  logic [pfgr_pkg::ADDR_W-1:0]   init_r;

  // Store
  logic [7:0] mem [pfgr_pkg::MEM_DEPTH];
  logic [7:0] rdata_r;
  logic [7:0] out_r;

  logic [9:0]  x_acc;
  logic [5:0]  p0;
  logic [6:0]  page_acc;
  logic [7:0]  glyph_bits;
  logic [15:0] shifted;
  logic [7:0]  page_mask;
  logic [7:0]  acc_mask;
  logic        is_glyph;
  logic        x_ok, pg_ok, y_pix_ok;
  logic        rd_ok;
  logic [pfgr_pkg::ADDR_W-1:0] acc_addr;
  logic [pfgr_pkg::ADDR_W-1:0] addr;
  logic [7:0]  wdata;
  logic        mem_we, mem_re;

  // Capture request fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_tdata[1:0];
      x_r        <= in_tdata[10:2];
      y_r        <= in_tdata[19:11];
      code_r     <= in_tdata[27:20];
      on_r       <= in_tdata[28];
      page_r     <= in_tdata[31:29];
    end
  end

  // Target of the current pixel or glyph access
  always_comb begin
    is_glyph   = (req_type_r == pfgr_pkg::REQ_GLYPH);
    x_acc      = {x_r[8], x_r} + {7'd0, col_r};
    p0         = y_r[8:3];
    page_acc   = {p0[5], p0} + {6'd0, half_r};
    glyph_bits = pfgr_pkg::glyph_col(code_r, col_r);
    shifted    = {8'd0, glyph_bits} << y_r[2:0];
    page_mask  = (page_acc[pfgr_pkg::PG_W-1:0] == pfgr_pkg::PG_W'(pfgr_pkg::PAGE_COUNT - 1))
                 ? pfgr_pkg::LAST_PAGE_MASK : 8'hFF;
    if (is_glyph)
      acc_mask = (half_r ? shifted[15:8] : shifted[7:0]) & page_mask;
    else
      acc_mask = 8'd1 << y_r[2:0];
    x_ok     = !x_acc[9] && (x_acc[8:0] < 9'(pfgr_pkg::PANEL_WIDTH));
    pg_ok    = !page_acc[6] && (page_acc[5:0] < 6'(pfgr_pkg::PAGE_COUNT));
    y_pix_ok = !y_r[8] && (y_r[7:0] < 8'(pfgr_pkg::PANEL_HEIGHT));
    acc_addr = {page_acc[pfgr_pkg::PG_W-1:0], x_acc[pfgr_pkg::COL_W-1:0]};
    rd_ok    = ({1'b0, page_r} < 4'(pfgr_pkg::PAGE_COUNT)) && !x_r[8] &&
               ({1'b0, x_r[7:0]} < 9'(pfgr_pkg::PANEL_WIDTH));
  end

  // Status to controller
  always_comb begin
    stat.in_type    = in_tdata[1:0];
    stat.acc_valid  = is_glyph ? (x_ok && pg_ok && (acc_mask != 8'd0)) : (x_ok && y_pix_ok);
    stat.acc_last   = !is_glyph || ((col_r == 3'(pfgr_pkg::GLYPH_COLS - 1)) && half_r);
    stat.page_ok    = ({1'b0, page_r} < 4'(pfgr_pkg::PAGE_COUNT));
    stat.sweep_last = (sweep_r == pfgr_pkg::COL_W'(pfgr_pkg::PANEL_WIDTH - 1));
    stat.init_last  = (init_r == pfgr_pkg::ADDR_W'(pfgr_pkg::MEM_DEPTH - 1));
    stat.rd_ok      = rd_ok;
  end

  // Store port address and write data
  always_comb begin
    mem_we = cmd.init_wr | cmd.clr_wr | cmd.acc_wr;
    mem_re = cmd.acc_rd | cmd.byte_rd;
    if (cmd.init_wr)
      addr = init_r;
    else if (cmd.clr_wr)
      addr = {page_r, sweep_r};
    else if (cmd.byte_rd)
      addr = {page_r, x_r[pfgr_pkg::COL_W-1:0]};
    else
      addr = acc_addr;
    if (cmd.init_wr || cmd.clr_wr)
      wdata = 8'd0;
    else if (is_glyph || on_r)
      wdata = rdata_r | acc_mask;
    else
      wdata = rdata_r & ~acc_mask;
  end

  always_ff @(posedge clk) begin
    if (mem_we)
      mem[addr] <= wdata;
    if (mem_re)
      rdata_r <= mem[addr];
  end

  // Glyph access stepping: two pages per column
  always_comb begin
    col_nxt  = col_r;
    half_nxt = half_r;
    if (cmd.load) begin
      col_nxt  = 3'd0;
      half_nxt = 1'b0;
    end else if (cmd.acc_next) begin
      half_nxt = !half_r;
      if (half_r)
        col_nxt = col_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= 3'd0;
      half_r  <= 1'b0;
      sweep_r <= '0;
      init_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      half_r <= half_nxt;
      if (cmd.load)
        sweep_r <= '0;
      else if (cmd.clr_wr)
        sweep_r <= sweep_r + pfgr_pkg::COL_W'(1);
      if (cmd.init_wr)
        init_r <= init_r + pfgr_pkg::ADDR_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load)
      out_r <= ((req_type_r == pfgr_pkg::REQ_READ) && rd_ok) ? rdata_r : 8'd0;
  end

  assign out_tdata = out_r;

endmodule

// ===== rtl/pfgr_ctrl.sv =====
// Controller of the glyph renderer: sequences store sweeps, read-modify-write
// accesses and result handoff, and owns both handshakes.
// Depends on pfgr_pkg.
module pfgr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  pfgr_pkg::dp_stat_t stat,
  output pfgr_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ACHK = 3'd2;
  localparam logic [2:0] S_AWR  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_BRD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.init_last)
          state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          unique case (stat.in_type)
            pfgr_pkg::REQ_GLYPH,
            pfgr_pkg::REQ_PIXEL: state_nxt = S_ACHK;
            pfgr_pkg::REQ_CLEAR: state_nxt = S_CLR;
            pfgr_pkg::REQ_READ:  state_nxt = S_BRD;
          endcase
        end
      end
      S_ACHK: begin
        // in-panel access: read now, write next cycle; else skip it
        if (stat.acc_valid) begin
          cmd.acc_rd = 1'b1;
          state_nxt  = S_AWR;
        end else begin
          cmd.acc_next = 1'b1;
          if (stat.acc_last)
            state_nxt = S_DONE;
        end
      end
      S_AWR: begin
        cmd.acc_wr   = 1'b1;
        cmd.acc_next = 1'b1;
        state_nxt    = stat.acc_last ? S_DONE : S_ACHK;
      end
      S_CLR: begin
        if (!stat.page_ok) begin
          state_nxt = S_DONE;
        end else begin
          cmd.clr_wr = 1'b1;
          if (stat.sweep_last)
            state_nxt = S_DONE;
        end
      end
      S_BRD: begin
        cmd.byte_rd = stat.rd_ok;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)
      out_valid_nxt = 1'b1;
    else if (out_tready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/page_framebuffer_glyph_render_core.sv =====
// Page framebuffer with 5x7 glyph renderer, top level.
// Pixel and glyph requests read and rewrite each in-panel page byte they touch,
// skipping clipped ones; a glyph walks 10 page/column slots. A byte read fetches
// one column byte and a page clear zeroes the PANEL_WIDTH bytes of one page. One
// request at a time; the next one is taken the cycle after the result is loaded.
// After reset a clearing pass zeroes all MEM_DEPTH (1024) bytes of the store.
module page_framebuffer_glyph_render_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] req_type, [10:2] x_pos, [19:11] y_pos, [27:20] char_code,
  // [28] pixel_on, [31:29] page_index
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data
  output logic [7:0]  out_tdata
);

  pfgr_pkg::dp_cmd_t  cmd;
  pfgr_pkg::dp_stat_t stat;

  pfgr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

  pfgr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

endmodule
